// ===== hdl/ntp_offset_median_filter_defines.svh =====
// ---------------------------------------------------------------------------
// NTP offset median filter assertion macros
// Shared concurrent assertion forms used by the filter RTL.
// ---------------------------------------------------------------------------
`ifndef NTP_OFFSET_MEDIAN_FILTER_DEFINES_SVH
`define NTP_OFFSET_MEDIAN_FILTER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define NTPOFS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define NTPOFS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ntpofs_pkg.sv =====
// ---------------------------------------------------------------------------
// NTP offset median filter package
// Widths, codes and control structs shared by the filter modules.
// ---------------------------------------------------------------------------
package ntpofs_pkg;

   localparam int MAX_SAMPLES = 16;
   localparam int IDX_W       = $clog2(MAX_SAMPLES);
   localparam int FILL_W      = $clog2(MAX_SAMPLES + 1);

   localparam int TIME_W  = 62;
   localparam int SEQ_W   = 32;
   localparam int WIDE_W  = 64;
   localparam int OUT_W   = 63;
   localparam int DRIFT_W = 48;
   localparam int CNT_W   = 32;
   localparam int CFG_W   = 5;

   // 1e6 * 2^16 = 15625 * 2^22
   localparam int             MULT_W      = 14;
   localparam logic [MULT_W-1:0] DRIFT_MULT = 14'd15625;
   localparam int             DRIFT_SHIFT = 22;
   localparam int             HALF_W      = WIDE_W / 2;
   localparam int             PP_W        = HALF_W + MULT_W;
   localparam int             PROD_W      = WIDE_W + MULT_W;
   localparam int             DIVIDEND_W  = PROD_W + DRIFT_SHIFT;
   localparam int             DIV_CNT_W   = $clog2(DIVIDEND_W);
   localparam int             QUO_W       = DRIFT_W + 1;

   localparam logic OP_REQUEST   = 1'b0;
   localparam logic OP_RESPONSE  = 1'b1;
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_STALE = 1'b1;

   localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(8);

   typedef struct packed {
      logic              wr_en;
      logic              start;
      logic [IDX_W-1:0]  head;
      logic [FILL_W-1:0] fill;
      logic [WIDE_W-1:0] wr_offset;
      logic [WIDE_W-1:0] wr_delay;
   } med_cmd_type;

   typedef struct packed {
      logic              done;
      logic [WIDE_W-1:0] offset;
      logic [WIDE_W-1:0] delay;
   } med_rsp_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [WIDE_W-1:0]     divisor;
   } div_cmd_type;

   typedef struct packed {
      logic             done;
      logic             over;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== hdl/ntpofs_if.sv =====
// ---------------------------------------------------------------------------
// NTP offset median filter channels
// Valid/ready channels for requests, responses and the window register.
// ---------------------------------------------------------------------------
interface ntpofs_req_if import ntpofs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              operation;
   logic [TIME_W-1:0] local_time;
   logic [SEQ_W-1:0]  resp_sequence;
   logic [TIME_W-1:0] resp_t2;
   logic [TIME_W-1:0] resp_t3;

   modport source (output valid, operation, local_time, resp_sequence, resp_t2, resp_t3,
                   input ready);
   modport sink (input valid, operation, local_time, resp_sequence, resp_t2, resp_t3,
                 output ready);
endinterface

interface ntpofs_rsp_if import ntpofs_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      status;
   logic [SEQ_W-1:0]          issued_sequence;
   logic signed [OUT_W-1:0]   median_offset;
   logic signed [OUT_W-1:0]   median_round_trip;
   logic signed [DRIFT_W-1:0] drift_ppm_q16;
   logic [TIME_W-1:0]         peak_abs_offset;
   logic [CNT_W-1:0]          exchange_count;

   modport source (output valid, status, issued_sequence, median_offset, median_round_trip,
                   drift_ppm_q16, peak_abs_offset, exchange_count, input ready);
   modport sink (input valid, status, issued_sequence, median_offset, median_round_trip,
                 drift_ppm_q16, peak_abs_offset, exchange_count, output ready);
endinterface

interface ntpofs_csr_if import ntpofs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] sample_window;

   modport source (output valid, sample_window, input ready);
   modport sink (input valid, sample_window, output ready);
endinterface

// ===== hdl/ntp_offset_median_filter.sv =====
// ---------------------------------------------------------------------------
// NTP offset median filter
// Client side of a clock sync exchange with median filtered offset and delay.
// ---------------------------------------------------------------------------
// One request at a time. A sync request or a stale response goes straight to
// the output register. An accepted response makes the median selector try
// candidates, at most n for a window of n samples, until both medians are
// found. The median selector walks each candidate sample against the whole
// window through one comparator per window on a single read port. The drift
// divide (one bit per cycle) runs beside the median search when the drift is
// updated. The result is held in an output register, so the next request is
// taken while the previous result waits.

`include "ntp_offset_median_filter_defines.svh"

module ntp_offset_median_filter import ntpofs_pkg::*; (
   input logic         clock,
   input logic         reset,
   ntpofs_req_if.sink   req_ch,
   ntpofs_rsp_if.source rsp_ch,
   ntpofs_csr_if.sink   csr_ch
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DIFF   = 4'd1;
   localparam logic [3:0] S_SUM    = 4'd2;
   localparam logic [3:0] S_OFS    = 4'd3;
   localparam logic [3:0] S_STORE  = 4'd4;
   localparam logic [3:0] S_START  = 4'd5;
   localparam logic [3:0] S_MAG    = 4'd6;
   localparam logic [3:0] S_MUL_LO = 4'd7;
   localparam logic [3:0] S_MUL_HI = 4'd8;
   localparam logic [3:0] S_DIV_GO = 4'd9;
   localparam logic [3:0] S_DIV    = 4'd10;
   localparam logic [3:0] S_DRIFT  = 4'd11;
   localparam logic [3:0] S_WAIT   = 4'd12;
   localparam logic [3:0] S_PEAK   = 4'd13;
   localparam logic [3:0] S_FIN    = 4'd14;
   localparam logic [3:0] S_DONE   = 4'd15;

   logic [3:0]         state_ff, state_in;
   logic [CFG_W-1:0]   win_ff;
   logic [TIME_W-1:0]  pending_ff, pending_in;
   logic [SEQ_W-1:0]   seq_ff, seq_in;
   logic [TIME_W-1:0]  t2_ff, t3_ff, t4_ff;
   logic [WIDE_W-1:0]  d21_ff, d34_ff, d41_ff, d32_ff;
   logic [WIDE_W-1:0]  sum_ff, rtt_ff, ofs_ff, rtt_sat_ff;
   logic [WIDE_W-1:0]  last_ofs_ff, last_ofs_in, diff_ff, mag_ff, abs_ff;
   logic               neg_ff, drift_en_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [WIDE_W-1:0]  filt_ofs_ff, filt_ofs_in, filt_dly_ff, filt_dly_in;
   logic [DRIFT_W-1:0] drift_ff, drift_in;
   logic [TIME_W-1:0]  peak_ff, peak_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               status_ff, status_in;
   logic               med_seen_ff, med_seen_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic                      rsp_status_ff;
   logic [SEQ_W-1:0]          rsp_seq_ff;
   logic [OUT_W-1:0]          rsp_ofs_ff, rsp_dly_ff;
   logic [DRIFT_W-1:0]        rsp_drift_ff;
   logic [TIME_W-1:0]         rsp_peak_ff;
   logic [CNT_W-1:0]          rsp_count_ff;

   med_cmd_type med_cmd;
   med_rsp_type med_rsp;
   div_cmd_type div_cmd;
   div_rsp_type div_rsp;

   logic              req_fire, rsp_load;
   logic [FILL_W-1:0] win_len, fill_new;
   logic [FILL_W:0]   fill_inc;
   logic [QUO_W-1:0]  quo_limit, quo_sat;
   logic [PP_W-1:0]   pp_lo, pp_hi;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign rsp_load     = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   // out of range window lengths clamp to 1..MAX_SAMPLES
   always_comb begin
      if (win_ff == '0) begin
         win_len = FILL_W'(1);
      end else if (32'(win_ff) > MAX_SAMPLES) begin
         win_len = FILL_W'(MAX_SAMPLES);
      end else begin
         win_len = FILL_W'(win_ff);
      end
   end

   assign fill_inc = {1'b0, fill_ff} + 1'b1;
   assign fill_new = (fill_inc > {1'b0, win_len}) ? win_len : fill_inc[FILL_W-1:0];

   assign pp_lo = PP_W'(mag_ff[HALF_W-1:0]) * PP_W'(DRIFT_MULT);
   assign pp_hi = PP_W'(mag_ff[WIDE_W-1:HALF_W]) * PP_W'(DRIFT_MULT);

   assign quo_limit = neg_ff ? QUO_W'(1) << (DRIFT_W - 1) : (QUO_W'(1) << (DRIFT_W - 1)) - 1'b1;
   assign quo_sat   = (div_rsp.over || div_rsp.quotient > quo_limit) ? quo_limit
                                                                     : div_rsp.quotient;

   always_comb begin
      med_cmd           = '0;
      med_cmd.wr_offset = ofs_ff;
      med_cmd.wr_delay  = rtt_sat_ff;
      med_cmd.head      = head_ff;
      med_cmd.fill      = fill_ff;
      med_cmd.wr_en     = (state_ff == S_STORE);
      med_cmd.start     = (state_ff == S_START);
   end

   always_comb begin
      div_cmd.start    = (state_ff == S_DIV_GO);
      div_cmd.dividend = {prod_ff, {DRIFT_SHIFT{1'b0}}};
      div_cmd.divisor  = rtt_ff;
   end

   ntpofs_median u_median (
      .clock (clock),
      .reset (reset),
      .cmd   (med_cmd),
      .rsp   (med_rsp)
   );

   ntpofs_divider u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      pending_in   = pending_ff;
      seq_in       = seq_ff;
      last_ofs_in  = last_ofs_ff;
      fill_in      = fill_ff;
      head_in      = head_ff;
      filt_ofs_in  = filt_ofs_ff;
      filt_dly_in  = filt_dly_ff;
      drift_in     = drift_ff;
      peak_in      = peak_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      med_seen_in  = med_seen_ff | med_rsp.done;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               status_in = STATUS_OK;
               if (req_ch.operation == OP_REQUEST) begin
                  pending_in = req_ch.local_time;
                  seq_in     = seq_ff + 1'b1;
                  state_in   = S_DONE;
               end else if (req_ch.resp_sequence != seq_ff) begin
                  status_in = STATUS_STALE;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_DIFF;
               end
            end
         end
         S_DIFF:  state_in = S_SUM;
         S_SUM:   state_in = S_OFS;
         S_OFS:   state_in = S_STORE;
         S_STORE: begin
            head_in     = head_ff + 1'b1;
            fill_in     = fill_new;
            last_ofs_in = ofs_ff;
            state_in    = S_START;
         end
         S_START: begin
            med_seen_in = 1'b0;
            state_in    = drift_en_ff ? S_MAG : S_WAIT;
         end
         S_MAG:    state_in = S_MUL_LO;
         S_MUL_LO: state_in = S_MUL_HI;
         S_MUL_HI: state_in = S_DIV_GO;
         S_DIV_GO: state_in = S_DIV;
         S_DIV: begin
            if (div_rsp.done) begin
               state_in = S_DRIFT;
            end
         end
         S_DRIFT: begin
            drift_in = neg_ff ? DRIFT_W'(-quo_sat) : quo_sat[DRIFT_W-1:0];
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (med_seen_ff || med_rsp.done) begin
               filt_ofs_in = med_rsp.offset;
               filt_dly_in = med_rsp.delay;
               state_in    = S_PEAK;
            end
         end
         S_PEAK: state_in = S_FIN;
         S_FIN: begin
            if (abs_ff > {2'b00, peak_ff}) begin
               peak_in = abs_ff[TIME_W-1:0];
            end
            if (count_ff != '1) begin
               count_in = count_ff + 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         win_ff       <= WINDOW_RESET;
         pending_ff   <= '0;
         seq_ff       <= '0;
         last_ofs_ff  <= '0;
         fill_ff      <= '0;
         head_ff      <= '0;
         filt_ofs_ff  <= '0;
         filt_dly_ff  <= '0;
         drift_ff     <= '0;
         peak_ff      <= '0;
         count_ff     <= '0;
         status_ff    <= STATUS_OK;
         med_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_ch.valid && csr_ch.ready) begin
            win_ff <= csr_ch.sample_window;
         end
         pending_ff   <= pending_in;
         seq_ff       <= seq_in;
         last_ofs_ff  <= last_ofs_in;
         fill_ff      <= fill_in;
         head_ff      <= head_in;
         filt_ofs_ff  <= filt_ofs_in;
         filt_dly_ff  <= filt_dly_in;
         drift_ff     <= drift_in;
         peak_ff      <= peak_in;
         count_ff     <= count_in;
         status_ff    <= status_in;
         med_seen_ff  <= med_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         t2_ff <= req_ch.resp_t2;
         t3_ff <= req_ch.resp_t3;
         t4_ff <= req_ch.local_time;
      end
      if (state_ff == S_DIFF) begin
         d21_ff <= {2'b00, t2_ff} - {2'b00, pending_ff};
         d34_ff <= {2'b00, t3_ff} - {2'b00, t4_ff};
         d41_ff <= {2'b00, t4_ff} - {2'b00, pending_ff};
         d32_ff <= {2'b00, t3_ff} - {2'b00, t2_ff};
      end
      if (state_ff == S_SUM) begin
         sum_ff <= d21_ff + d34_ff;
         rtt_ff <= d41_ff - d32_ff;
      end
      if (state_ff == S_OFS) begin
         // halve toward zero: round negative sums up before the shift
         ofs_ff <= WIDE_W'($signed(sum_ff + WIDE_W'(sum_ff[WIDE_W-1])) >>> 1);
         if (!rtt_ff[WIDE_W-1] && rtt_ff[WIDE_W-2]) begin
            rtt_sat_ff <= {2'b00, {(WIDE_W-2){1'b1}}};
         end else if (rtt_ff[WIDE_W-1] && !rtt_ff[WIDE_W-2]) begin
            rtt_sat_ff <= {2'b11, {(WIDE_W-2){1'b0}}};
         end else begin
            rtt_sat_ff <= rtt_ff;
         end
      end
      if (state_ff == S_STORE) begin
         diff_ff     <= ofs_ff - last_ofs_ff;
         drift_en_ff <= (fill_new >= FILL_W'(2)) && !rtt_ff[WIDE_W-1] && (rtt_ff != '0);
      end
      if (state_ff == S_MAG) begin
         neg_ff <= diff_ff[WIDE_W-1];
         mag_ff <= diff_ff[WIDE_W-1] ? -diff_ff : diff_ff;
      end
      if (state_ff == S_MUL_LO) begin
         prod_ff <= PROD_W'(pp_lo);
      end
      if (state_ff == S_MUL_HI) begin
         prod_ff <= prod_ff + {pp_hi, {HALF_W{1'b0}}};
      end
      if (state_ff == S_PEAK) begin
         abs_ff <= filt_ofs_ff[WIDE_W-1] ? -filt_ofs_ff : filt_ofs_ff;
      end
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_seq_ff    <= seq_ff;
         rsp_ofs_ff    <= filt_ofs_ff[OUT_W-1:0];
         rsp_dly_ff    <= filt_dly_ff[OUT_W-1:0];
         rsp_drift_ff  <= drift_ff;
         rsp_peak_ff   <= peak_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.status            = rsp_status_ff;
   assign rsp_ch.issued_sequence   = rsp_seq_ff;
   assign rsp_ch.median_offset     = $signed(rsp_ofs_ff);
   assign rsp_ch.median_round_trip = $signed(rsp_dly_ff);
   assign rsp_ch.drift_ppm_q16     = $signed(rsp_drift_ff);
   assign rsp_ch.peak_abs_offset   = rsp_peak_ff;
   assign rsp_ch.exchange_count    = rsp_count_ff;

   `NTPOFS_ASSERT_NEXT(a_busy_after_request, clock, reset, req_fire, !req_ch.ready, "request accepted while busy")
   `NTPOFS_ASSERT_SAME(a_median_nonempty, clock, reset, med_cmd.start, fill_ff != '0, "median started on empty window")
   `NTPOFS_ASSERT_NEXT(a_count_only_at_fin, clock, reset, state_ff != S_FIN, $stable(count_ff), "exchange count moved outside finish")

endmodule

// ===== hdl/ntpofs_median.sv =====
// ---------------------------------------------------------------------------
// NTP offset median selector
// Holds both sample windows and finds the upper median of each by counting,
// one candidate at a time against every sample through one comparator each.
// ---------------------------------------------------------------------------
module ntpofs_median import ntpofs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  med_cmd_type cmd,
   output med_rsp_type rsp
);

   localparam logic [2:0] M_IDLE  = 3'd0;
   localparam logic [2:0] M_CAND  = 3'd1;
   localparam logic [2:0] M_LOAD  = 3'd2;
   localparam logic [2:0] M_SCAN  = 3'd3;
   localparam logic [2:0] M_CHECK = 3'd4;

   logic [WIDE_W-1:0] ofs_mem [MAX_SAMPLES];
   logic [WIDE_W-1:0] dly_mem [MAX_SAMPLES];
   logic [WIDE_W-1:0] ofs_rd_ff, dly_rd_ff;

   logic [2:0]        state_ff, state_in;
   logic [IDX_W-1:0]  base_ff, base_in;
   logic [FILL_W-1:0] n_ff, n_in, i_ff, i_in, j_ff, j_in;
   logic [WIDE_W-1:0] cand_ofs_ff, cand_ofs_in, cand_dly_ff, cand_dly_in;
   logic [FILL_W-1:0] lt_ofs_ff, lt_ofs_in, eq_ofs_ff, eq_ofs_in;
   logic [FILL_W-1:0] lt_dly_ff, lt_dly_in, eq_dly_ff, eq_dly_in;
   logic              fnd_ofs_ff, fnd_ofs_in, fnd_dly_ff, fnd_dly_in;
   logic [WIDE_W-1:0] med_ofs_ff, med_ofs_in, med_dly_ff, med_dly_in;
   logic              done_ff, done_in;

   logic [FILL_W-1:0] rd_idx;
   logic [IDX_W-1:0]  raddr;
   logic [FILL_W-1:0] k_rank;
   logic              hit_ofs, hit_dly;

   always_comb begin
      case (state_ff)
         M_CAND:  rd_idx = i_ff;
         M_SCAN:  rd_idx = j_ff;
         default: rd_idx = '0;
      endcase
   end

   assign raddr  = base_ff + rd_idx[IDX_W-1:0];
   assign k_rank = n_ff >> 1;
   assign hit_ofs = (lt_ofs_ff <= k_rank) && (k_rank < lt_ofs_ff + eq_ofs_ff);
   assign hit_dly = (lt_dly_ff <= k_rank) && (k_rank < lt_dly_ff + eq_dly_ff);

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         ofs_mem[cmd.head] <= cmd.wr_offset;
         dly_mem[cmd.head] <= cmd.wr_delay;
      end
      ofs_rd_ff <= ofs_mem[raddr];
      dly_rd_ff <= dly_mem[raddr];
   end

   always_comb begin
      state_in    = state_ff;
      base_in     = base_ff;
      n_in        = n_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      cand_ofs_in = cand_ofs_ff;
      cand_dly_in = cand_dly_ff;
      lt_ofs_in   = lt_ofs_ff;
      eq_ofs_in   = eq_ofs_ff;
      lt_dly_in   = lt_dly_ff;
      eq_dly_in   = eq_dly_ff;
      fnd_ofs_in  = fnd_ofs_ff;
      fnd_dly_in  = fnd_dly_ff;
      med_ofs_in  = med_ofs_ff;
      med_dly_in  = med_dly_ff;
      done_in     = 1'b0;
      case (state_ff)
         M_IDLE: begin
            if (cmd.start) begin
               base_in    = cmd.head - cmd.fill[IDX_W-1:0];
               n_in       = cmd.fill;
               i_in       = '0;
               fnd_ofs_in = 1'b0;
               fnd_dly_in = 1'b0;
               state_in   = M_CAND;
            end
         end
         M_CAND: begin
            state_in = M_LOAD;
         end
         M_LOAD: begin
            cand_ofs_in = ofs_rd_ff;
            cand_dly_in = dly_rd_ff;
            lt_ofs_in   = '0;
            eq_ofs_in   = '0;
            lt_dly_in   = '0;
            eq_dly_in   = '0;
            j_in        = FILL_W'(1);
            state_in    = M_SCAN;
         end
         M_SCAN: begin
            // read data belongs to the sample addressed in the previous cycle
            if ($signed(ofs_rd_ff) < $signed(cand_ofs_ff)) begin
               lt_ofs_in = lt_ofs_ff + 1'b1;
            end else if (ofs_rd_ff == cand_ofs_ff) begin
               eq_ofs_in = eq_ofs_ff + 1'b1;
            end
            if ($signed(dly_rd_ff) < $signed(cand_dly_ff)) begin
               lt_dly_in = lt_dly_ff + 1'b1;
            end else if (dly_rd_ff == cand_dly_ff) begin
               eq_dly_in = eq_dly_ff + 1'b1;
            end
            if (j_ff < n_ff) begin
               j_in = j_ff + 1'b1;
            end else begin
               state_in = M_CHECK;
            end
         end
         M_CHECK: begin
            if (!fnd_ofs_ff && hit_ofs) begin
               fnd_ofs_in = 1'b1;
               med_ofs_in = cand_ofs_ff;
            end
            if (!fnd_dly_ff && hit_dly) begin
               fnd_dly_in = 1'b1;
               med_dly_in = cand_dly_ff;
            end
            if (((fnd_ofs_ff || hit_ofs) && (fnd_dly_ff || hit_dly)) ||
                (i_ff + 1'b1 == n_ff)) begin
               done_in  = 1'b1;
               state_in = M_IDLE;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = M_CAND;
            end
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= M_IDLE;
         done_ff    <= 1'b0;
         fnd_ofs_ff <= 1'b0;
         fnd_dly_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         done_ff    <= done_in;
         fnd_ofs_ff <= fnd_ofs_in;
         fnd_dly_ff <= fnd_dly_in;
      end
      base_ff     <= base_in;
      n_ff        <= n_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      cand_ofs_ff <= cand_ofs_in;
      cand_dly_ff <= cand_dly_in;
      lt_ofs_ff   <= lt_ofs_in;
      eq_ofs_ff   <= eq_ofs_in;
      lt_dly_ff   <= lt_dly_in;
      eq_dly_ff   <= eq_dly_in;
      med_ofs_ff  <= med_ofs_in;
      med_dly_ff  <= med_dly_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.offset = med_ofs_ff;
   assign rsp.delay  = med_dly_ff;

endmodule

// ===== hdl/ntpofs_divider.sv =====
// ---------------------------------------------------------------------------
// NTP offset drift divider
// Restoring divider, one quotient bit per cycle, with a sticky overflow
// flag once a set bit shifts out of the quotient register.
// ---------------------------------------------------------------------------
module ntpofs_divider import ntpofs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_rsp_type rsp
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] dvd_ff, dvd_in;
   logic [WIDE_W-1:0]     dsr_ff, dsr_in;
   logic [WIDE_W-1:0]     rem_ff, rem_in;
   logic [QUO_W-1:0]      quo_ff, quo_in;
   logic                  over_ff, over_in;

   logic [WIDE_W:0] rem_sh;
   logic            fits;

   assign rem_sh = {rem_ff, dvd_ff[DIVIDEND_W-1]};
   assign fits   = rem_sh >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      over_in = over_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIVIDEND_W - 1);
         dvd_in  = cmd.dividend;
         dsr_in  = cmd.divisor;
         rem_in  = '0;
         quo_in  = '0;
         over_in = 1'b0;
      end else if (busy_ff) begin
         rem_in  = fits ? WIDE_W'(rem_sh - {1'b0, dsr_ff}) : rem_sh[WIDE_W-1:0];
         quo_in  = {quo_ff[QUO_W-2:0], fits};
         over_in = over_ff | quo_ff[QUO_W-1];
         dvd_in  = {dvd_ff[DIVIDEND_W-2:0], 1'b0};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      dvd_ff  <= dvd_in;
      dsr_ff  <= dsr_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      over_ff <= over_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.over     = over_ff;
   assign rsp.quotient = quo_ff;

endmodule
